@@ rtl/plist_pkg.sv @@
package plist_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ACTION_W  = 3;
    localparam int POS_W     = 5;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FIRST = 3'd0,
        ACT_INS_LAST  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FIRST = 3'd3,
        ACT_DEL_AT    = 3'd4,
        ACT_DEL_LAST  = 3'd5,
        ACT_SEARCH    = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               load;
        logic               ins;
        logic               del;
        logic [VALUE_W-1:0] value;
    } cell_cmd_t;

    // Request state carried from the cell stage to the response stage.
    typedef struct packed {
        status_t            status;
        logic               search;
        logic [COUNT_W-1:0] count;
    } stage_t;

endpackage

@@ rtl/plist_ifs.sv @@
interface plist_req_if;
    import plist_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [POS_W-1:0]      position;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface plist_rsp_if;
    import plist_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [COUNT_W-1:0]  item_count;

    modport source (output valid, output status, output found_position, output item_count,
                    input ready);
    modport sink   (input valid, input status, input found_position, input item_count,
                    output ready);
endinterface

@@ rtl/plist_cell.sv @@
module plist_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                            clk,
    input  plist_pkg::cell_cmd_t            cmd,
    input  logic [CW-1:0]                   idx,
    input  logic [plist_pkg::VALUE_W-1:0]   left_data,
    input  logic [plist_pkg::VALUE_W-1:0]   right_data,
    input  logic                            occupied,
    output logic [plist_pkg::VALUE_W-1:0]   data,
    output logic                            match
);
    import plist_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               match_reg;

    // Insert opens a gap at idx by pulling from the left; delete closes it
    // by pulling from the right.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > idx)
                data_next = left_data;
            else if (MY_IDX == idx)
                data_next = cmd.value;
        end
        else if (cmd.del && (MY_IDX >= idx))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (cmd.load)
            match_reg <= occupied && (data_reg == cmd.value);
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ rtl/plist_resp.sv @@
module plist_resp #(
    parameter int DEPTH = plist_pkg::DEPTH_DEF,
    parameter int CW    = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    input  plist_pkg::stage_t  s1,
    input  logic [DEPTH-1:0]   match,
    output logic               adv,
    plist_rsp_if.source        rsp
);
    import plist_pkg::*;

    logic               valid_reg;
    status_t            status_reg;
    logic [POS_W-1:0]   found_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               hit;
    logic [CW-1:0]      found_c;
    status_t            status_next;
    logic [POS_W-1:0]   found_next;

    // Lowest matching cell wins.
    always_comb
    begin
        hit     = 1'b0;
        found_c = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                found_c = CW'(i + 1);
            end
        end
    end

    always_comb
    begin
        status_next = s1.status;
        found_next  = '0;
        if (s1.search)
        begin
            status_next = hit ? ST_OK : ST_NOTFOUND;
            found_next  = hit ? POS_W'(found_c) : '0;
        end
    end

    assign adv = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            count_reg  <= s1.count;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.found_position = found_reg;
    assign rsp.item_count     = count_reg;

endmodule

@@ rtl/positional_list_engine_top.sv @@
// Ordered list engine for up to DEPTH signed 32-bit words.
// Requests arrive on the req channel (action, position, value) and every
// request yields exactly one word on the rsp channel (status, found_position,
// item_count). Both channels move a word when valid and ready are high at a
// rising clock edge.
// The list lives in a chain of DEPTH cells, one word per cell, position 1 in
// cell 0. An insert shifts cells at and past the target one place back, a
// delete pulls them one place forward, and a search compares every occupied
// cell at once, all in the cycle the request is taken.
// A request passes through the cell stage, then the response stage that picks
// the first matching cell. One request is taken per cycle as long as the
// response side keeps up.
// When the receiver holds rsp.ready low, one response waits in the output
// register and one more in the cell stage; after that req.ready drops.
// Reset empties the list (count zero) and clears both stages. Cell contents
// are not reset; cells past the count are never read.
module positional_list_engine_top #(
    parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    plist_req_if.sink   req,
    plist_rsp_if.source rsp
);
    import plist_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               s1_valid_reg;
    stage_t             s1_reg;

    logic               acc;
    logic               adv;
    cell_cmd_t          cmd;
    logic [CW-1:0]      idx;
    status_t            status_a;
    logic               search_a;

    logic [EW-1:0]      pos_e;
    logic [EW-1:0]      cnt_e;
    logic               full;
    logic               empty;

    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]   match;

    assign req.ready = !s1_valid_reg || adv;
    assign acc       = req.valid && req.ready;

    assign pos_e = EW'(req.position);
    assign cnt_e = EW'(count_reg);
    assign full  = (cnt_e == EW'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        cmd.load  = acc;
        cmd.ins   = 1'b0;
        cmd.del   = 1'b0;
        cmd.value = req.value;
        idx       = '0;
        status_a  = ST_OK;
        search_a  = 1'b0;
        unique case (req.action)
            ACT_INS_FIRST:
            begin
                if (full) status_a = ST_FULL;
                else cmd.ins = acc;
            end
            ACT_INS_LAST:
            begin
                idx = count_reg;
                if (full) status_a = ST_FULL;
                else cmd.ins = acc;
            end
            ACT_INS_AT:
            begin
                idx = CW'(pos_e - EW'(1));
                if ((pos_e == '0) || (pos_e > cnt_e + EW'(1))) status_a = ST_BADPOS;
                else if (full) status_a = ST_FULL;
                else cmd.ins = acc;
            end
            ACT_DEL_FIRST:
            begin
                if (empty) status_a = ST_EMPTY;
                else cmd.del = acc;
            end
            ACT_DEL_AT:
            begin
                idx = CW'(pos_e - EW'(1));
                if (empty) status_a = ST_EMPTY;
                else if ((pos_e == '0) || (pos_e > cnt_e)) status_a = ST_BADPOS;
                else cmd.del = acc;
            end
            ACT_DEL_LAST:
            begin
                idx = count_reg - CW'(1);
                if (empty) status_a = ST_EMPTY;
                else cmd.del = acc;
            end
            ACT_SEARCH:
            begin
                search_a = 1'b1;
            end
            default:
            begin
                // Unknown action: no change, plain ok response.
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + CW'(1);
        else if (cmd.del)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req.ready)
                s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg.status <= status_a;
            s1_reg.search <= search_a;
            s1_reg.count  <= COUNT_W'(count_next);
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] I_C = CW'(i);

        logic [VALUE_W-1:0] left_d;
        logic [VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = req.value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        plist_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (idx),
            .left_data  (left_d),
            .right_data (right_d),
            .occupied   (I_C < count_reg),
            .data       (cell_data[i]),
            .match      (match[i])
        );
    end

    plist_resp #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_resp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .s1       (s1_reg),
        .match    (match),
        .adv      (adv),
        .rsp      (rsp)
    );

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("item count above depth");

    a_ins_del_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins && cmd.del))
        else $error("insert and delete in the same cycle");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not raise the count");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not lower the count");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("cell stage lost a word under stall");
`endif

endmodule

@@ verif/positional_list_engine_top_tb.sv @@
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
    import plist_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;
    localparam int TIMEOUT_NS = 1000000;

    typedef struct {
        status_t            status;
        logic [POS_W-1:0]   found_position;
        logic [COUNT_W-1:0] item_count;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    plist_req_if req_ch ();
    plist_rsp_if rsp_ch ();

    positional_list_engine_top #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list, position 1 at the front of the queue.
    logic [VALUE_W-1:0] list_cells[$];
    list_rsp_t          expected_rsps[$];
    int                 fail_count = 0;
    logic               hold_go;
    logic               steady_flow;
    int                 hold_cnt = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic list_rsp_t predict_list_op(input logic [ACTION_W-1:0] act,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [VALUE_W-1:0] val);
        list_rsp_t r;
        int n;
        int idx;
        r.status = ST_OK;
        r.found_position = '0;
        n = list_cells.size();
        case (act)
            ACT_INS_FIRST:
                if (n >= LIST_DEPTH) r.status = ST_FULL;
                else list_cells.push_front(val);
            ACT_INS_LAST:
                if (n >= LIST_DEPTH) r.status = ST_FULL;
                else list_cells.push_back(val);
            ACT_INS_AT:
                // Position is checked before capacity.
                if (pos < 1 || int'(pos) > n + 1) r.status = ST_BADPOS;
                else if (n >= LIST_DEPTH) r.status = ST_FULL;
                else list_cells.insert(int'(pos) - 1, val);
            ACT_DEL_FIRST:
                if (n == 0) r.status = ST_EMPTY;
                else void'(list_cells.pop_front());
            ACT_DEL_AT:
                if (n == 0) r.status = ST_EMPTY;
                else if (pos < 1 || int'(pos) > n) r.status = ST_BADPOS;
                else list_cells.delete(int'(pos) - 1);
            ACT_DEL_LAST:
                if (n == 0) r.status = ST_EMPTY;
                else void'(list_cells.pop_back());
            ACT_SEARCH:
            begin
                r.status = ST_NOTFOUND;
                for (idx = 0; idx < n; idx++) begin
                    if (r.status == ST_NOTFOUND && list_cells[idx] == val) begin
                        r.status = ST_OK;
                        r.found_position = POS_W'(idx + 1);
                    end
                end
            end
            default: ;
        endcase
        r.item_count = COUNT_W'(list_cells.size());
        return r;
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val);
        if (!steady_flow && $urandom_range(99) < 10) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.value    <= val;
        do @(posedge clk); while (!req_ch.ready);
        expected_rsps.push_back(predict_list_op(act, pos, val));
    endtask

    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_rsps.size() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return 32'($urandom_range(0, 7)) - 32'd4;  // tight cluster gives duplicates
        if (sel < 40) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    always @(posedge clk) begin
        list_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
                note_failure($sformatf("unexpected response word: status %0d found %0d count %0d",
                                       rsp_ch.status, rsp_ch.found_position,
                                       rsp_ch.item_count));
            end
            else begin
                want = expected_rsps.pop_front();
                if (rsp_ch.status !== want.status ||
                    rsp_ch.found_position !== want.found_position ||
                    rsp_ch.item_count !== want.item_count)
                    note_failure($sformatf({"mismatch: expected status %0d found %0d count %0d,",
                                            " got status %0d found %0d count %0d"},
                                           want.status, want.found_position, want.item_count,
                                           rsp_ch.status, rsp_ch.found_position,
                                           rsp_ch.item_count));
            end
        end
    end

    // Response side: random stalls, or a long hold-off once it is requested.
    always @(posedge clk) begin
        if (hold_cnt > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_go) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt <= HOLD_CYCLES - 1;
        end
        else begin
            rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 10);
        end
    end

    task automatic test_directed_edges();
        send_request(ACT_SEARCH, 5'd0, 32'h0000_0005);
        send_request(ACT_DEL_FIRST, 5'd0, 32'h0);
        send_request(ACT_DEL_AT, 5'd1, 32'h0);
        send_request(ACT_DEL_LAST, 5'd0, 32'h0);
        // An empty list wins over a bad position.
        send_request(ACT_DEL_AT, 5'd0, 32'h0);
        send_request(ACT_INS_AT, 5'd0, 32'h1111_1111);
        send_request(ACT_INS_AT, 5'd2, 32'h2222_2222);
        send_request(ACT_INS_AT, 5'd1, 32'h8000_0000);
        send_request(ACT_INS_FIRST, 5'd0, 32'h7fff_ffff);
        send_request(ACT_INS_LAST, 5'd0, 32'h0000_0000);
        send_request(ACT_INS_AT, 5'd2, 32'hffff_ffff);
        send_request(ACT_INS_AT, 5'd5, 32'h1234_5678);
        send_request(ACT_SEARCH, 5'd0, 32'h0000_0000);
        send_request(ACT_SEARCH, 5'd0, 32'h7fff_ffff);
        send_request(ACT_SEARCH, 5'd0, 32'h0000_0bad);
        send_request(ACT_DEL_AT, 5'd0, 32'h0);
        send_request(ACT_DEL_AT, 5'd6, 32'h0);
        send_request(ACT_DEL_AT, 5'd3, 32'h0);
        send_request(ACT_DEL_FIRST, 5'd0, 32'h0);
        send_request(ACT_DEL_LAST, 5'd0, 32'h0);
        send_request(ACT_UNUSED, 5'd31, 32'hffff_ffff);
        send_request(ACT_SEARCH, 5'd31, 32'h8000_0000);
        send_request(ACT_DEL_AT, 5'd2, 32'h0);
        send_request(ACT_DEL_AT, 5'd1, 32'h0);
    endtask

    task automatic test_capacity_limits();
        while (list_cells.size() < LIST_DEPTH)
            send_request(ACT_INS_AT, POS_W'($urandom_range(1, list_cells.size() + 1)),
                         $urandom());
        send_request(ACT_INS_FIRST, 5'd0, 32'h5555_5555);
        send_request(ACT_INS_LAST, 5'd0, 32'haaaa_aaaa);
        send_request(ACT_INS_AT, POS_W'(LIST_DEPTH + 1), 32'h0);
        send_request(ACT_INS_AT, POS_W'(LIST_DEPTH + 2), 32'h0);
        send_request(ACT_INS_AT, 5'd0, 32'h0);
        send_request(ACT_SEARCH, 5'd0, list_cells[LIST_DEPTH - 1]);
        send_request(ACT_DEL_AT, POS_W'(LIST_DEPTH + 1), 32'h0);
        send_request(ACT_DEL_AT, POS_W'(LIST_DEPTH), 32'h0);
        while (list_cells.size() > 0)
            send_request(ACT_DEL_AT, POS_W'($urandom_range(1, list_cells.size())), 32'h0);
        send_request(ACT_DEL_AT, 5'd1, 32'h0);
    endtask

    task automatic test_random_traffic(input int n_items, input int ins_pct);
        int n;
        int r;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  val;
        repeat (n_items) begin
            n = list_cells.size();
            r = $urandom_range(99);
            pos = POS_W'($urandom_range(0, 31));
            val = pick_word();
            if (r < 2) begin
                act = ACT_UNUSED;
            end
            else if (r < 17) begin
                act = ACT_SEARCH;
                if (n > 0 && $urandom_range(99) < 70)
                    val = list_cells[$urandom_range(n - 1)];
            end
            else if ($urandom_range(99) < ins_pct) begin
                case ($urandom_range(2))
                    0: act = ACT_INS_FIRST;
                    1: act = ACT_INS_LAST;
                    default:
                    begin
                        act = ACT_INS_AT;
                        if ($urandom_range(99) < 85)
                            pos = POS_W'($urandom_range(1, n + 1));
                    end
                endcase
            end
            else begin
                case ($urandom_range(2))
                    0: act = ACT_DEL_FIRST;
                    1: act = ACT_DEL_LAST;
                    default:
                    begin
                        act = ACT_DEL_AT;
                        if (n > 0 && $urandom_range(99) < 85)
                            pos = POS_W'($urandom_range(1, n));
                    end
                endcase
            end
            send_request(act, pos, val);
        end
    endtask

    // The sender keeps offering words while the receiver is held off, so the
    // pipeline fills and the request side has to stall.
    task automatic test_output_backpressure();
        pause_until_drained();
        steady_flow <= 1'b1;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        test_random_traffic(24, 60);
        steady_flow <= 1'b0;
        pause_until_drained();
    endtask

    task automatic test_steady_stream();
        steady_flow <= 1'b1;
        test_random_traffic(300, 50);
        steady_flow <= 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = '0;
        req_ch.position = '0;
        req_ch.value = '0;
        hold_go = 1'b0;
        steady_flow = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_capacity_limits();
        pause_until_drained();
        test_random_traffic(300, 50);
        test_random_traffic(250, 80);
        test_output_backpressure();
        test_random_traffic(250, 20);
        test_steady_stream();
        test_random_traffic(300, 60);

        pause_until_drained();
        repeat (10) @(posedge clk);
        if (expected_rsps.size() != 0)
            note_failure($sformatf("%0d response words never arrived", expected_rsps.size()));
        if (fail_count == 0)
            $display("positional_list_engine_top verification clean");
        else
            $display("positional_list_engine_top verification failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("positional_list_engine_top verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/plist_pkg.sv
rtl/plist_ifs.sv
rtl/plist_cell.sv
rtl/plist_resp.sv
rtl/positional_list_engine_top.sv
verif/positional_list_engine_top_tb.sv
